@@ design/lpfr_pkg.sv @@
// Shared types, constants and helpers for the length-prefixed frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package lpfr_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_IDX_HOST_ID  = 2'd0;
    localparam logic [1:0] CFG_IDX_MAX_LEN  = 2'd1;
    localparam int         CFG_IDX_W        = 2;
    localparam int         CFG_DATA_W       = 8;

    localparam logic [7:0] HOST_ID_RESET    = 8'd0;
    localparam logic [6:0] MAX_LEN_RESET    = 7'd64;

    // Frame layout
    localparam logic [6:0] IDX_LENGTH       = 7'd0;
    localparam logic [6:0] IDX_TARGET       = 7'd1;
    localparam logic [6:0] IDX_KIND         = 7'd4;
    localparam logic [6:0] HEADER_BYTES     = 7'd5;
    localparam logic [7:0] MIN_HEADER_LEN   = 8'd5;
    localparam logic [7:0] MIN_FRAME_LEN    = 8'd6;
    localparam logic [7:0] MAX_FRAME_LEN    = 8'd120;
    localparam logic [7:0] KIND_DATA_A      = 8'd2;
    localparam logic [7:0] KIND_DATA_B      = 8'd3;

    // Verdict codes
    localparam logic [2:0] VERDICT_PENDING  = 3'd0;
    localparam logic [2:0] VERDICT_GOOD     = 3'd1;
    localparam logic [2:0] VERDICT_BAD_LEN  = 3'd2;
    localparam logic [2:0] VERDICT_BAD_TGT  = 3'd3;
    localparam logic [2:0] VERDICT_BAD_KIND = 3'd4;
    localparam logic [2:0] VERDICT_BAD_SUM  = 3'd5;
    localparam logic [2:0] VERDICT_BANNER   = 3'd6;

    typedef struct packed {
        logic [7:0] host_id;
        logic [6:0] max_frame_len;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [6:0] byte_index;
        logic       frame_done;
        logic [2:0] verdict;
    } t_result;

    // Reboot banner "Enter", one character per header position
    function automatic logic [7:0] banner_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h45;
            3'd1:    ch = 8'h6E;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h72;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ design/lpfr_in_if.sv @@
// Valid/ready channel carrying one received serial byte per request.
`timescale 1ns / 1ps
`default_nettype none

interface lpfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ design/lpfr_out_if.sv @@
// Valid/ready channel carrying one echoed byte with its frame status per request.
`timescale 1ns / 1ps
`default_nettype none

interface lpfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    logic       frame_done;
    logic [2:0] verdict;

    modport source (output valid, output data_byte, output byte_index,
                    output frame_done, output verdict, input ready);
    modport sink   (input valid, input data_byte, input byte_index,
                    input frame_done, input verdict, output ready);
endinterface

`default_nettype wire

@@ design/lpfr_parser.sv @@
// Frame parser: byte position, header capture, running sum and verdict logic.
`timescale 1ns / 1ps
`default_nettype none

module lpfr_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_rx_byte,
    input  wire lpfr_pkg::t_cfg  i_cfg,
    output lpfr_pkg::t_result    o_result
);

    logic [6:0] r_byte_count, n_byte_count;
    logic [7:0] r_frame_length, n_frame_length;
    logic [7:0] r_running_sum, n_running_sum;
    logic [7:0] r_target_byte, n_target_byte;
    logic [7:0] r_kind_byte, n_kind_byte;
    logic       r_banner_match, n_banner_match;

    logic       in_header;
    logic [7:0] len_now;
    logic [7:0] sum_now;
    logic       banner_now;
    logic [7:0] next_pos;
    logic       done;
    logic [2:0] verdict;

    always_comb begin
        in_header  = (r_byte_count < lpfr_pkg::HEADER_BYTES);
        len_now    = (r_byte_count == lpfr_pkg::IDX_LENGTH) ? i_rx_byte : r_frame_length;
        sum_now    = r_running_sum + i_rx_byte;
        banner_now = r_banner_match &&
                     !(in_header && (i_rx_byte != lpfr_pkg::banner_char(r_byte_count[2:0])));
        next_pos   = {1'b0, r_byte_count} + 8'd1;

        done    = 1'b0;
        verdict = lpfr_pkg::VERDICT_PENDING;
        if (in_header) begin
            if ((len_now < lpfr_pkg::MIN_HEADER_LEN) ||
                (len_now > {1'b0, i_cfg.max_frame_len})) begin
                done    = 1'b1;
                verdict = lpfr_pkg::VERDICT_BAD_LEN;
            end
        end else if (next_pos >= r_frame_length) begin
            done = 1'b1;
            priority if (r_target_byte != i_cfg.host_id) begin
                verdict = lpfr_pkg::VERDICT_BAD_TGT;
            end else if ((r_kind_byte != lpfr_pkg::KIND_DATA_A) &&
                         (r_kind_byte != lpfr_pkg::KIND_DATA_B)) begin
                verdict = lpfr_pkg::VERDICT_BAD_KIND;
            end else if ((r_frame_length < lpfr_pkg::MIN_FRAME_LEN) ||
                         (r_frame_length > lpfr_pkg::MAX_FRAME_LEN) ||
                         (sum_now != 8'd0)) begin
                verdict = lpfr_pkg::VERDICT_BAD_SUM;
            end else begin
                verdict = lpfr_pkg::VERDICT_GOOD;
            end
        end else if (r_banner_match) begin
            // header spelled the reboot banner: the far end restarted
            done    = 1'b1;
            verdict = lpfr_pkg::VERDICT_BANNER;
        end

        o_result.data_byte  = i_rx_byte;
        o_result.byte_index = r_byte_count;
        o_result.frame_done = done;
        o_result.verdict    = verdict;
    end

    always_comb begin
        n_byte_count   = r_byte_count;
        n_frame_length = r_frame_length;
        n_running_sum  = r_running_sum;
        n_target_byte  = r_target_byte;
        n_kind_byte    = r_kind_byte;
        n_banner_match = r_banner_match;
        if (i_accept) begin
            if (done) begin
                n_byte_count   = '0;
                n_frame_length = '0;
                n_running_sum  = '0;
                n_target_byte  = '0;
                n_kind_byte    = '0;
                n_banner_match = 1'b1;
            end else begin
                n_byte_count   = next_pos[6:0];
                n_frame_length = len_now;
                n_running_sum  = sum_now;
                n_banner_match = banner_now;
                if (r_byte_count == lpfr_pkg::IDX_TARGET) begin
                    n_target_byte = i_rx_byte;
                end
                if (r_byte_count == lpfr_pkg::IDX_KIND) begin
                    n_kind_byte = i_rx_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_frame_length <= '0;
            r_running_sum  <= '0;
            r_target_byte  <= '0;
            r_kind_byte    <= '0;
            r_banner_match <= 1'b1;
        end else begin
            r_byte_count   <= n_byte_count;
            r_frame_length <= n_frame_length;
            r_running_sum  <= n_running_sum;
            r_target_byte  <= n_target_byte;
            r_kind_byte    <= n_kind_byte;
            r_banner_match <= n_banner_match;
        end
    end

`ifndef ASSERT_OFF
    a_restart_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && done) |=> (r_byte_count == '0) && r_banner_match && (r_running_sum == '0))
        else $error("parser did not restart after a verdict");

    a_bad_len_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (verdict == lpfr_pkg::VERDICT_BAD_LEN) |-> in_header)
        else $error("bad length verdict past the header");

    a_banner_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (verdict == lpfr_pkg::VERDICT_BANNER) |->
            (r_banner_match && (r_byte_count >= lpfr_pkg::HEADER_BYTES)))
        else $error("banner verdict without a banner match");
`endif

endmodule

`default_nettype wire

@@ design/length_prefixed_frame_receiver_core.sv @@
// Top level of the length-prefixed frame receiver: config registers and output skid stage.
// Usage:
//   i_rx   : valid/ready channel, one received serial byte per request.
//   o_res  : valid/ready channel, one result per byte: the byte echoed, its index
//            in the frame, a frame-done flag and a verdict (nonzero only on the
//            byte that ends or aborts the frame).
//   i_cfg_we/i_cfg_index/i_cfg_data: register writes, index 0 host_id,
//            index 1 max_frame_len (low 7 bits); other indexes are ignored.
//            Write only while no request is in flight.
// Output: each result is registered (output register, or skid entry if that is full).
// Throughput: one byte per cycle while i_rx.ready is high; parser state (count, length,
//   sum, header bytes, banner match) updates in the same cycle the byte is accepted.
// Stall: an output register plus one skid entry let a byte be accepted while a
//   result waits; i_rx.ready drops only when both hold results.
// Reset (synchronous, active low): parser restarts at index 0, output and skid
//   emptied, host_id = 0, max_frame_len = 64.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_receiver_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    lpfr_in_if.sink                                i_rx,
    lpfr_out_if.source                             o_res,
    input  wire logic                              i_cfg_we,
    input  wire logic [lpfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lpfr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    lpfr_pkg::t_cfg    r_cfg;
    lpfr_pkg::t_result parse_res;
    lpfr_pkg::t_result r_out;
    lpfr_pkg::t_result r_skid;
    logic              r_out_valid;
    logic              r_skid_valid;
    logic              accept;
    logic              pop;

    assign i_rx.ready = !r_skid_valid;
    assign accept     = i_rx.valid && !r_skid_valid;
    assign pop        = r_out_valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.host_id       <= lpfr_pkg::HOST_ID_RESET;
            r_cfg.max_frame_len <= lpfr_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lpfr_pkg::CFG_IDX_HOST_ID: r_cfg.host_id       <= i_cfg_data;
                lpfr_pkg::CFG_IDX_MAX_LEN: r_cfg.max_frame_len <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    lpfr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx.rx_byte),
        .i_cfg     (r_cfg),
        .o_result  (parse_res)
    );

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || pop) begin
                r_out       <= parse_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= parse_res;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.data_byte  = r_out.data_byte;
    assign o_res.byte_index = r_out.byte_index;
    assign o_res.frame_done = r_out.frame_done;
    assign o_res.verdict    = r_out.verdict;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_pending_iff_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.frame_done == (r_out.verdict != lpfr_pkg::VERDICT_PENDING)))
        else $error("verdict and frame_done disagree");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && pop) |=> !r_skid_valid && r_out_valid)
        else $error("skid entry not moved to output on a pop");
`endif

endmodule

`default_nettype wire

@@ dv/lpfr_frame_checker.sv @@
// Frame receiver checker: predicts each echoed byte and verdict, compares the results in order.
`timescale 1ns / 1ps

module lpfr_frame_checker
    import lpfr_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    lpfr_in_if                           i_rx,
    lpfr_out_if                          i_res,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                           o_pending,
    output int                           o_mismatches
);

    localparam logic [39:0] BANNER_TEXT = "Enter";
    localparam int          MAX_PRINTED = 40;

    // register copies
    logic [7:0] host_id;
    logic [6:0] len_limit;

    // parser copy
    logic [6:0] frame_pos;
    logic [7:0] frame_len;
    logic [7:0] byte_sum;
    logic [7:0] target_seen;
    logic [7:0] kind_seen;
    logic       banner_ok;

    t_result results_due[$];
    int      mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic void restart_frame_state();
        frame_pos   = '0;
        frame_len   = '0;
        byte_sum    = '0;
        target_seen = '0;
        kind_seen   = '0;
        banner_ok   = 1'b1;
    endfunction

    function automatic t_result parse_byte(input logic [7:0] rx);
        t_result    r;
        logic [6:0] pos;
        logic       done;
        logic [2:0] verdict;
        pos     = frame_pos;
        done    = 1'b0;
        verdict = VERDICT_PENDING;
        if (pos == IDX_LENGTH) begin
            frame_len = rx;
        end else if (pos == IDX_TARGET) begin
            target_seen = rx;
        end else if (pos == IDX_KIND) begin
            kind_seen = rx;
        end
        if (pos < HEADER_BYTES && rx != BANNER_TEXT[8 * (4 - int'(pos)) +: 8]) begin
            banner_ok = 1'b0;
        end
        byte_sum = byte_sum + rx;

        if (pos >= HEADER_BYTES) begin
            if ({1'b0, pos} + 8'd1 >= frame_len) begin
                done = 1'b1;
                if (target_seen != host_id) begin
                    verdict = VERDICT_BAD_TGT;
                end else if (kind_seen != KIND_DATA_A && kind_seen != KIND_DATA_B) begin
                    verdict = VERDICT_BAD_KIND;
                end else if (frame_len < MIN_FRAME_LEN || frame_len > MAX_FRAME_LEN ||
                             byte_sum != 8'd0) begin
                    verdict = VERDICT_BAD_SUM;
                end else begin
                    verdict = VERDICT_GOOD;
                end
            end else if (banner_ok) begin
                done    = 1'b1;
                verdict = VERDICT_BANNER;
            end
        end else if (frame_len < MIN_HEADER_LEN || frame_len > {1'b0, len_limit}) begin
            // length byte is checked on every header byte
            done    = 1'b1;
            verdict = VERDICT_BAD_LEN;
        end

        if (done) begin
            restart_frame_state();
        end else begin
            frame_pos = pos + 7'd1;
        end

        r.data_byte  = rx;
        r.byte_index = pos;
        r.frame_done = done;
        r.verdict    = verdict;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTED) begin
            $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            host_id   = HOST_ID_RESET;
            len_limit = MAX_LEN_RESET;
            restart_frame_state();
            results_due.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IDX_HOST_ID: host_id   = i_cfg_data;
                    CFG_IDX_MAX_LEN: len_limit = i_cfg_data[6:0];
                    default: ;
                endcase
            end

            // a result leaves only after its request has been registered, so compare before queuing
            if (i_res.valid && i_res.ready) begin
                seen.data_byte  = i_res.data_byte;
                seen.byte_index = i_res.byte_index;
                seen.frame_done = i_res.frame_done;
                seen.verdict    = i_res.verdict;
                if (results_due.size() == 0) begin
                    report_mismatch("result with no request pending", seen.data_byte, 0);
                end else begin
                    want = results_due.pop_front();
                    if (seen.data_byte !== want.data_byte)
                        report_mismatch("data_byte", seen.data_byte, want.data_byte);
                    if (seen.byte_index !== want.byte_index)
                        report_mismatch("byte_index", seen.byte_index, want.byte_index);
                    if (seen.frame_done !== want.frame_done)
                        report_mismatch("frame_done", seen.frame_done, want.frame_done);
                    if (seen.verdict !== want.verdict)
                        report_mismatch("verdict", seen.verdict, want.verdict);
                end
            end

            if (i_rx.valid && i_rx.ready) begin
                results_due.push_back(parse_byte(i_rx.rx_byte));
            end
            o_pending <= results_due.size();
        end
    end

endmodule

@@ dv/tb_length_prefixed_frame_receiver_core.sv @@
// Testbench top: drives frames, noise and register writes into the frame receiver and gives the verdict.
`timescale 1ns / 1ps

module tb_length_prefixed_frame_receiver_core;
    import lpfr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
    localparam logic [39:0]          BANNER_TEXT     = "Enter";
    localparam int                   PHASE_BYTES     = 200;
    localparam int                   TINY_PHASE      = 4;
    localparam int                   LAST_PHASE      = 7;

    typedef logic [7:0] t_byte_q[$];

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending_cnt;
    int                    mismatch_cnt;

    bit         quiet_tail = 1'b0;
    bit         gaps_on    = 1'b1;
    logic [7:0] host_now;
    logic [6:0] limit_now;
    int         bytes_sent = 0;

    lpfr_in_if  rx_ch ();
    lpfr_out_if res_ch ();

    length_prefixed_frame_receiver_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    lpfr_frame_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending_cnt),
        .o_mismatches (mismatch_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side: runs of ready with random stall bursts
    initial begin : result_ready_gen
        int run;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            res_ch.ready <= 1'b1;
            run = $urandom_range(60, 1);
            repeat (run) @(posedge i_clk);
            if (!quiet_tail && $urandom_range(2, 0) != 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(11, 1)) @(posedge i_clk);
            end
        end
    end

    function automatic t_byte_q build_frame(input logic [7:0] len, input logic [7:0] target,
                                            input logic [7:0] kind, input bit sum_ok);
        t_byte_q    q;
        logic [7:0] total;
        int         n;
        n = (len < MIN_FRAME_LEN) ? int'(MIN_FRAME_LEN) : int'(len);
        q.push_back(len);
        q.push_back(target);
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
        q.push_back(kind);
        while (q.size() < n - 1) q.push_back(8'($urandom));
        total = '0;
        foreach (q[i]) total += q[i];
        q.push_back(sum_ok ? 8'(8'd0 - total) : 8'($urandom));
        return q;
    endfunction

    function automatic t_byte_q banner_frame();
        t_byte_q q;
        for (int i = 0; i < 5; i++) q.push_back(BANNER_TEXT[8 * (4 - i) +: 8]);
        q.push_back(8'($urandom));
        return q;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        if (!quiet_tail && gaps_on && $urandom_range(5, 0) == 0) begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(11, 1)) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input t_byte_q q);
        foreach (q[i]) push_byte(q[i]);
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        rx_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // both registers, then a write to an unused index that must be ignored
    task automatic configure(input logic [7:0] host, input logic [7:0] len_data);
        host_now  = host;
        limit_now = len_data[6:0];
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_HOST_ID;
        cfg_data  <= host;
        @(posedge i_clk);
        cfg_index <= CFG_IDX_MAX_LEN;
        cfg_data  <= len_data;
        @(posedge i_clk);
        cfg_index <= $urandom_range(1, 0) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B;
        cfg_data  <= 8'($urandom);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_frame();
        t_byte_q    q;
        int         roll;
        int         top_len;
        logic [7:0] len;
        logic [7:0] kind;
        roll    = $urandom_range(99, 0);
        top_len = (limit_now > 120) ? 120 : int'(limit_now);
        if ($urandom_range(3, 0) != 0)
            len = 8'($urandom_range((top_len < 20) ? top_len : 20, 6));
        else
            len = 8'($urandom_range(top_len, 6));
        kind = $urandom_range(1, 0) ? KIND_DATA_A : KIND_DATA_B;

        if (roll < 55) begin
            q = build_frame(len, host_now, kind, 1'b1);
        end else if (roll < 63) begin
            q = build_frame(len, host_now ^ 8'($urandom_range(255, 1)), kind, 1'b1);
        end else if (roll < 70) begin
            q = build_frame(len, host_now, 8'($urandom), 1'b1);
        end else if (roll < 78) begin
            q = build_frame(len, host_now, kind, 1'b0);
        end else if (roll < 82) begin
            q = build_frame(MIN_HEADER_LEN, host_now, kind, 1'b1);
        end else if (roll < 85 && limit_now > 120) begin
            // checksum fine but length beyond 120
            q = build_frame(8'($urandom_range(limit_now, 121)), host_now, kind, 1'b1);
        end else if (roll < 89 && limit_now >= BANNER_TEXT[39:32]) begin
            q = banner_frame();
        end else if (roll < 95) begin
            if ($urandom_range(1, 0))
                q.push_back(8'($urandom_range(4, 0)));
            else
                q.push_back(8'($urandom_range(255, int'(limit_now) + 1)));
        end else begin
            repeat ($urandom_range(6, 1)) q.push_back(8'($urandom));
        end
        send_frame(q);
    endtask

    initial begin : stimulus
        int         start;
        int         budget;
        logic [7:0] host_sel;
        logic [7:0] len_sel;

        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_IDX_HOST_ID;
        cfg_data      <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values first
        host_now  = HOST_ID_RESET;
        limit_now = MAX_LEN_RESET;
        send_frame(build_frame(MIN_FRAME_LEN, host_now, KIND_DATA_B, 1'b1));
        push_byte(8'd0);
        push_byte(8'd4);
        push_byte({1'b0, MAX_LEN_RESET} + 8'd1);
        push_byte(8'hFF);
        drain();
        configure(8'h12, 8'hFF);
        send_frame(banner_frame());
        send_frame(build_frame(MIN_HEADER_LEN, host_now, KIND_DATA_A, 1'b1));

        for (int phase = 0; phase <= LAST_PHASE; phase++) begin
            drain();
            host_sel = 8'($urandom);
            len_sel  = {1'($urandom), 7'($urandom_range(127, 6))};
            budget   = PHASE_BYTES;
            case (phase)
                0:          begin host_sel = 8'h00; len_sel = 8'hFF; end
                1:          begin host_sel = 8'hFF; len_sel = 8'h06; end
                TINY_PHASE: begin len_sel = {1'($urandom), 7'($urandom_range(5, 0))}; budget = 40; end
                LAST_PHASE: len_sel = 8'h7F;
                default: ;
            endcase
            quiet_tail = (phase == LAST_PHASE);
            configure(host_sel, len_sel);
            start = bytes_sent;
            while (bytes_sent - start < budget) begin
                if ($urandom_range(7, 0) == 0) gaps_on = !gaps_on;
                if (limit_now < MIN_FRAME_LEN[6:0])
                    push_byte(8'($urandom));
                else
                    random_frame();
            end
        end

        drain();
        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/lpfr_pkg.sv
design/lpfr_in_if.sv
design/lpfr_out_if.sv
design/lpfr_parser.sv
design/length_prefixed_frame_receiver_core.sv
dv/lpfr_frame_checker.sv
dv/tb_length_prefixed_frame_receiver_core.sv
